### src/tss_pkg.sv
// tss_pkg: shared types, step labels and the microcode table of the two-stack sorter
// used by the sequencer, the datapath and the top level; depends on nothing
package tss_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 32;
    localparam int PC_W          = 3;

    typedef logic [PC_W-1:0] t_pc;

    // datapath operation selected by the current control word
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_POP,
        OP_FETCH,
        OP_CMP,
        OP_EMIT_START,
        OP_EMIT
    } t_op;

    // what a step waits for before it may advance
    typedef enum logic [1:0] {
        W_NONE,
        W_IN,
        W_OUT
    } t_wait;

    // branch condition of a step
    typedef enum logic [2:0] {
        C_TRUE,
        C_NOT_LAST,
        C_SRC_EMPTY,
        C_MOVE,
        C_EMIT_LAST
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_wait wait_on;
        t_cond cond;
        t_pc   next_t;
        t_pc   next_f;
    } t_ctrl;

    // status flags from the datapath back to the sequencer
    typedef struct packed {
        logic in_fire;
        logic in_last;
        logic src_empty;
        logic move;
        logic out_free;
        logic emit_last;
    } t_status;

    // step labels
    localparam t_pc ST_LOAD       = t_pc'(0);
    localparam t_pc ST_POP        = t_pc'(1);
    localparam t_pc ST_FETCH      = t_pc'(2);
    localparam t_pc ST_CMP        = t_pc'(3);
    localparam t_pc ST_EMIT_START = t_pc'(4);
    localparam t_pc ST_EMIT       = t_pc'(5);

    // microcode rom: one control word per step
    function automatic t_ctrl ucode_word(t_pc pc);
        t_ctrl w;
        w = '{op: OP_NOP, wait_on: W_NONE, cond: C_TRUE, next_t: ST_LOAD, next_f: ST_LOAD};
        unique case (pc)
            ST_LOAD:       w = '{op: OP_LOAD, wait_on: W_IN, cond: C_NOT_LAST,
                                 next_t: ST_LOAD, next_f: ST_POP};
            ST_POP:        w = '{op: OP_POP, wait_on: W_NONE, cond: C_SRC_EMPTY,
                                 next_t: ST_EMIT_START, next_f: ST_FETCH};
            ST_FETCH:      w = '{op: OP_FETCH, wait_on: W_NONE, cond: C_TRUE,
                                 next_t: ST_CMP, next_f: ST_CMP};
            ST_CMP:        w = '{op: OP_CMP, wait_on: W_NONE, cond: C_MOVE,
                                 next_t: ST_CMP, next_f: ST_POP};
            ST_EMIT_START: w = '{op: OP_EMIT_START, wait_on: W_NONE, cond: C_TRUE,
                                 next_t: ST_EMIT, next_f: ST_EMIT};
            ST_EMIT:       w = '{op: OP_EMIT, wait_on: W_OUT, cond: C_EMIT_LAST,
                                 next_t: ST_LOAD, next_f: ST_EMIT};
            default:       w = '{op: OP_NOP, wait_on: W_NONE, cond: C_TRUE,
                                 next_t: ST_LOAD, next_f: ST_LOAD};
        endcase
        return w;
    endfunction

endpackage

### src/tss_if.sv
// tss_in_if / tss_out_if: valid-ready channels carrying input and result items
// depends on tss_pkg for the data width
interface tss_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [tss_pkg::DATA_W-1:0] value;
    logic                              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface tss_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [tss_pkg::DATA_W-1:0] sorted_value;
    logic                              final_res;

    modport source (output valid, output sorted_value, output final_res, input ready);
    modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

### src/tss_seq.sv
// tss_seq: step counter and microcode lookup with conditional jumps
// depends on tss_pkg (control word, status struct, rom function)
module tss_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tss_pkg::t_status i_stat,
    output tss_pkg::t_op     o_op
);

    tss_pkg::t_pc   r_pc;
    tss_pkg::t_pc   n_pc;
    tss_pkg::t_ctrl w_word;
    logic           w_go;
    logic           w_cond;

    // current control word
    assign w_word = tss_pkg::ucode_word(r_pc);
    assign o_op   = w_word.op;

    // wait qualifier
    always_comb begin
        unique case (w_word.wait_on)
            tss_pkg::W_NONE: w_go = 1'b1;
            tss_pkg::W_IN:   w_go = i_stat.in_fire;
            tss_pkg::W_OUT:  w_go = i_stat.out_free;
            default:         w_go = 1'b1;
        endcase
    end

    // branch condition
    always_comb begin
        unique case (w_word.cond)
            tss_pkg::C_TRUE:      w_cond = 1'b1;
            tss_pkg::C_NOT_LAST:  w_cond = !i_stat.in_last;
            tss_pkg::C_SRC_EMPTY: w_cond = i_stat.src_empty;
            tss_pkg::C_MOVE:      w_cond = i_stat.move;
            tss_pkg::C_EMIT_LAST: w_cond = i_stat.emit_last;
            default:              w_cond = 1'b1;
        endcase
    end

    // next step
    always_comb begin
        if (!w_go) begin
            n_pc = r_pc;
        end else if (w_cond) begin
            n_pc = w_word.next_t;
        end else begin
            n_pc = w_word.next_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= tss_pkg::ST_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

### src/tss_datapath.sv
// tss_datapath: source and helper stack memories, counters, compare and output register
// depends on tss_pkg and the tss_in_if / tss_out_if channels
module tss_datapath #(
    parameter int DEPTH = tss_pkg::DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tss_pkg::t_op     i_op,
    output tss_pkg::t_status o_stat,
    tss_in_if.sink           i_in,
    tss_out_if.source        o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef logic signed [tss_pkg::DATA_W-1:0] t_data;

    // stack memories
    t_data src_mem [DEPTH];
    t_data hlp_mem [DEPTH];

    t_data         r_src_rd;
    t_data         r_hlp_rd;
    logic [CW-1:0] r_scnt, n_scnt;
    logic [CW-1:0] r_hcnt, n_hcnt;
    logic [CW-1:0] r_idx, n_idx;
    t_data         r_x, n_x;
    t_data         r_odata, n_odata;
    logic          r_olast, n_olast;
    logic          r_ovalid, n_ovalid;

    logic          src_we, src_re, hlp_we, hlp_re;
    logic [AW-1:0] src_waddr, src_raddr, hlp_waddr, hlp_raddr;
    t_data         src_wdata, hlp_wdata;

    logic [CW-1:0] w_scnt_dec, w_hcnt_dec, w_hcnt_dec2, w_idx_inc;
    logic          w_in_fire, w_move, w_out_free, w_idx_last;

    assign w_scnt_dec  = r_scnt - CW'(1);
    assign w_hcnt_dec  = r_hcnt - CW'(1);
    assign w_hcnt_dec2 = r_hcnt - CW'(2);
    assign w_idx_inc   = r_idx + CW'(1);

    // handshake and status
    assign i_in.ready         = (i_op == tss_pkg::OP_LOAD);
    assign w_in_fire          = i_in.valid && i_in.ready;
    assign w_move             = (r_hcnt != '0) && (r_hlp_rd > r_x);
    assign w_out_free         = !r_ovalid || o_out.ready;
    assign w_idx_last         = (w_idx_inc == r_hcnt);

    assign o_stat.in_fire     = w_in_fire;
    assign o_stat.in_last     = i_in.last;
    assign o_stat.src_empty   = (r_scnt == '0);
    assign o_stat.move        = w_move;
    assign o_stat.out_free    = w_out_free;
    assign o_stat.emit_last   = w_idx_last;

    assign o_out.valid        = r_ovalid;
    assign o_out.sorted_value = r_odata;
    assign o_out.final_res    = r_olast;

    // operation decode
    always_comb begin
        n_scnt    = r_scnt;
        n_hcnt    = r_hcnt;
        n_idx     = r_idx;
        n_x       = r_x;
        n_odata   = r_odata;
        n_olast   = r_olast;
        n_ovalid  = r_ovalid && !o_out.ready;
        src_we    = 1'b0;
        src_re    = 1'b0;
        hlp_we    = 1'b0;
        hlp_re    = 1'b0;
        src_waddr = r_scnt[AW-1:0];
        src_raddr = w_scnt_dec[AW-1:0];
        hlp_waddr = r_hcnt[AW-1:0];
        hlp_raddr = w_hcnt_dec[AW-1:0];
        src_wdata = i_in.value;
        hlp_wdata = r_x;
        unique case (i_op)
            tss_pkg::OP_LOAD: begin
                // push the item unless the source stack is full
                if (w_in_fire && (r_scnt < CW'(DEPTH))) begin
                    src_we = 1'b1;
                    n_scnt = r_scnt + CW'(1);
                end
            end
            tss_pkg::OP_POP: begin
                if (r_scnt != '0) begin
                    src_re = 1'b1;
                    n_scnt = w_scnt_dec;
                end
            end
            tss_pkg::OP_FETCH: begin
                // latch popped value, fetch helper top
                n_x    = r_src_rd;
                hlp_re = 1'b1;
            end
            tss_pkg::OP_CMP: begin
                if (w_move) begin
                    // larger helper top goes back to the source stack
                    src_we    = 1'b1;
                    src_wdata = r_hlp_rd;
                    n_scnt    = r_scnt + CW'(1);
                    n_hcnt    = w_hcnt_dec;
                    hlp_re    = 1'b1;
                    hlp_raddr = w_hcnt_dec2[AW-1:0];
                end else begin
                    hlp_we = 1'b1;
                    n_hcnt = r_hcnt + CW'(1);
                end
            end
            tss_pkg::OP_EMIT_START: begin
                n_idx     = '0;
                hlp_re    = 1'b1;
                hlp_raddr = '0;
            end
            tss_pkg::OP_EMIT: begin
                // helper bottom first into the output register
                if (w_out_free) begin
                    n_odata   = r_hlp_rd;
                    n_olast   = w_idx_last;
                    n_ovalid  = 1'b1;
                    n_idx     = w_idx_inc;
                    hlp_re    = 1'b1;
                    hlp_raddr = w_idx_inc[AW-1:0];
                    if (w_idx_last) begin
                        n_scnt = '0;
                        n_hcnt = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // source stack memory
    always_ff @(posedge i_clk) begin
        if (src_we) begin
            src_mem[src_waddr] <= src_wdata;
        end
        if (src_re) begin
            r_src_rd <= src_mem[src_raddr];
        end
    end

    // helper stack memory
    always_ff @(posedge i_clk) begin
        if (hlp_we) begin
            hlp_mem[hlp_waddr] <= hlp_wdata;
        end
        if (hlp_re) begin
            r_hlp_rd <= hlp_mem[hlp_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt   <= '0;
            r_hcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_scnt   <= n_scnt;
            r_hcnt   <= n_hcnt;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_x     <= n_x;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

endmodule

### src/two_stack_sorter_unit.sv
// two_stack_sorter_unit: loads one item per cycle until last, then sorts and emits.
// Sort: each value popped from the source stack (moved entries are popped again) passes
// the pop, fetch and compare steps, each helper entry moved back takes another compare
// step, and a pop step on the empty source stack ends the sort.
// Emit: a setup step, then one result per cycle while the output is taken.
// Reset (synchronous, active low) clears the step counter, stack counts and output valid;
// stack contents are undefined until written and need no clearing pass.
module two_stack_sorter_unit #(
    parameter int DEPTH = tss_pkg::DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tss_in_if.sink    i_in,
    tss_out_if.source o_out
);

    tss_pkg::t_op     w_op;
    tss_pkg::t_status w_stat;

    // microcode sequencer
    tss_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_op    (w_op)
    );

    // stacks and compare datapath
    tss_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_stat  (w_stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // a last item starts the sort on the next cycle
    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last) |=> (w_op == tss_pkg::OP_POP))
        else $error("sort did not start after last item");

    // a stalled result keeps the sequencer in the emit step
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == tss_pkg::OP_EMIT && o_out.valid && !o_out.ready)
            |=> (w_op == tss_pkg::OP_EMIT))
        else $error("emit step left while output stalled");

    // the final result returns the block to loading
    a_final_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == tss_pkg::OP_EMIT && w_stat.out_free && w_stat.emit_last)
            |=> (w_op == tss_pkg::OP_LOAD && o_out.valid && o_out.final_res))
        else $error("final item not followed by load step");
`endif

endmodule

### verif/two_stack_sorter_unit_tb.sv
`timescale 1ns / 100ps
// two_stack_sorter_unit_tb: self-checking bench, a directed table then random data sets,
// every result compared with a typed table value or a stack-sort predictor kept inside the bench
// depends on tss_pkg, tss_in_if / tss_out_if and two_stack_sorter_unit
module two_stack_sorter_unit_tb;

    localparam int SORT_DEPTH   = tss_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 130;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_NS     = 2_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCTS [4] = '{0, 10, 30, 60};

    typedef logic signed [tss_pkg::DATA_W-1:0] t_val;

    localparam t_val VAL_MAX = 32'sh7FFF_FFFF;
    localparam t_val VAL_MIN = 32'sh8000_0000;
    localparam t_val VAL_NEG = 32'shFFFF_FFFF;

    // one result item as the output channel shows it
    typedef struct packed {
        t_val value;
        logic is_final;
    } t_sorted;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        t_val value;
        logic last;
        bit   typed;
        t_val want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tss_in_if  in_if();
    tss_out_if out_if();

    two_stack_sorter_unit #(.DEPTH(SORT_DEPTH)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // predictor state: load stack, ordering stack and their fill counts
    t_val    load_stack  [SORT_DEPTH];
    t_val    order_stack [SORT_DEPTH];
    int      load_count  = 0;
    int      order_count = 0;
    t_sorted sort_result [$];
    t_sorted sorted_q    [$];

    int err_count     = 0;
    int in_gap_pct    = 20;
    int out_stall_pct = 20;
    int hold_request  = 0;

    // single values with known results, then short sets with extremes and equal values
    t_row directed_rows [23] = '{
        '{VAL_MAX,        1'b1, 1'b1, VAL_MAX},
        '{VAL_MIN,        1'b1, 1'b1, VAL_MIN},
        '{32'sd0,         1'b1, 1'b1, 32'sd0},
        '{VAL_NEG,        1'b1, 1'b1, VAL_NEG},
        '{32'sd5,         1'b0, 1'b0, 32'sd0},
        '{-32'sd3,        1'b0, 1'b0, 32'sd0},
        '{32'sd5,         1'b1, 1'b0, 32'sd0},
        '{VAL_MAX,        1'b0, 1'b0, 32'sd0},
        '{VAL_MIN,        1'b0, 1'b0, 32'sd0},
        '{32'sd0,         1'b1, 1'b0, 32'sd0},
        '{32'sd1,         1'b0, 1'b0, 32'sd0},
        '{32'sd2,         1'b0, 1'b0, 32'sd0},
        '{32'sd3,         1'b0, 1'b0, 32'sd0},
        '{32'sd4,         1'b1, 1'b0, 32'sd0},
        '{32'sd4,         1'b0, 1'b0, 32'sd0},
        '{32'sd3,         1'b0, 1'b0, 32'sd0},
        '{32'sd2,         1'b0, 1'b0, 32'sd0},
        '{32'sd1,         1'b1, 1'b0, 32'sd0},
        '{VAL_MIN,        1'b0, 1'b0, 32'sd0},
        '{VAL_MIN,        1'b0, 1'b0, 32'sd0},
        '{VAL_MAX,        1'b1, 1'b0, 32'sd0},
        '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
        '{32'shAAAA_AAAA, 1'b1, 1'b0, 32'sd0}
    };

    always #1 i_clk = ~i_clk;

    task report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // push one value; on the last item sort the set with the two stacks
    function automatic void stack_sort_accept(input t_val v, input logic lst);
        t_val x;
        sort_result.delete();
        if (load_count < SORT_DEPTH) begin
            load_stack[load_count] = v;
            load_count++;
        end
        if (!lst)
            return;
        order_count = 0;
        while (load_count > 0) begin
            load_count--;
            x = load_stack[load_count];
            // larger ordering entries go back onto the load stack
            while (order_count > 0 && order_stack[order_count-1] > x) begin
                order_count--;
                load_stack[load_count] = order_stack[order_count];
                load_count++;
            end
            order_stack[order_count] = x;
            order_count++;
        end
        // bottom of the ordering stack comes out first
        for (int k = 0; k < order_count; k++)
            sort_result.push_back(t_sorted'{order_stack[k], k == order_count - 1});
        order_count = 0;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // full range, a narrow band that repeats values, or the extremes, zero and minus one
    function automatic t_val rand_value(input int mode);
        t_val picks [6];
        picks = '{VAL_MAX, VAL_MIN, 32'sd0, VAL_NEG, VAL_MAX - 1, VAL_MIN + 1};
        if (mode == 0)
            return t_val'($urandom());
        if (mode == 1)
            return t_val'(int'($urandom_range(14)) - 7);
        return picks[$urandom_range(5)];
    endfunction

    // offer one item, wait for it to be taken, then predict its results
    task send_item(input t_val v, input logic lst, input bit typed, input t_val want);
        if (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) begin
            in_if.valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        in_if.last  <= lst;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        stack_sort_accept(v, lst);
        if (typed)
            sorted_q.push_back(t_sorted'{want, 1'b1});
        else
            foreach (sort_result[k]) sorted_q.push_back(sort_result[k]);
    endtask

    // stimulus
    initial begin
        int loaded;
        int set_idx;
        int n;
        int mode;
        int r;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.value  <= '0;
        in_if.last   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
            send_item(directed_rows[i].value, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);

        // random data sets
        loaded  = 0;
        set_idx = 0;
        while (loaded < RANDOM_ITEMS) begin
            in_gap_pct    = IDLE_PCTS[$urandom_range(3)];
            out_stall_pct = IDLE_PCTS[$urandom_range(3)];
            r = $urandom_range(99);
            if (set_idx == 0) begin
                // overflow: the items past capacity are dropped
                n = SORT_DEPTH + 3;
            end else if (set_idx == 2) begin
                // receiver holds off so the next set backs up at the input
                n = 5;
                hold_request = HOLD_CYCLES;
            end else if (r < 70) begin
                n = $urandom_range(6, 1);
            end else if (r < 90) begin
                n = $urandom_range(16, 7);
            end else begin
                n = $urandom_range(SORT_DEPTH, 17);
            end
            // sender pauses until everything has drained
            if (set_idx == 5 && sorted_q.size() != 0) begin
                in_if.valid <= 1'b0;
                while (sorted_q.size() != 0) @(posedge i_clk);
            end
            mode = $urandom_range(2);
            for (int i = 0; i < n; i++)
                send_item(rand_value(mode), i == n - 1, 1'b0, 32'sd0);
            loaded += (n < SORT_DEPTH) ? n : SORT_DEPTH;
            set_idx++;
        end

        // drain and finish
        in_if.valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("two_stack_sorter_unit regression: pass");
        else
            $display("two_stack_sorter_unit regression: fail");
        $finish;
    end

    // result side: check each taken item, then choose ready for the next cycle
    initial begin
        int      stall_left;
        t_sorted want;
        stall_left = 0;
        out_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                if (sorted_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d final %b",
                                              out_if.sorted_value, out_if.final_res));
                end else begin
                    want = sorted_q.pop_front();
                    if (out_if.sorted_value !== want.value)
                        report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                                  out_if.sorted_value, want.value));
                    if (out_if.final_res !== want.is_final)
                        report_mismatch($sformatf("final_res %b, expected %b for %0d",
                                                  out_if.final_res, want.is_final, want.value));
                end
            end
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (out_stall_pct > 0 && $urandom_range(99) < out_stall_pct) begin
                stall_left = gap_len() - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("two_stack_sorter_unit regression: fail");
        $finish;
    end

endmodule

### two_stack_sorter_unit.f
src/tss_pkg.sv
src/tss_if.sv
src/tss_seq.sv
src/tss_datapath.sv
src/two_stack_sorter_unit.sv
verif/two_stack_sorter_unit_tb.sv
